FILE: hdl/lesc_pkg.sv
// Shared types and constants for the LOOK elevator scheduler.
package lesc_pkg;

  // Default number of floors
  localparam int FLOORS_DEF = 32;

  // Input field widths
  localparam int ACTION_W = 2;
  localparam int FLOOR_W  = 5;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_HALL = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CAR  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STEP = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SERVE,
    ST_SCAN,
    ST_FINISH
  } lesc_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;     // capture the input transaction
    logic serve;     // apply call/destination, or serve the current floor
    logic advance;   // move scan pointer one floor on
    logic found;     // scan pointer hit a pending floor: move there
    logic reverse;   // turn round and restart the scan
    logic load_out;  // write the result register
  } lesc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_step;   // captured action is a service step
    logic hit;       // floor under the scan pointer is pending
    logic at_end;    // scan pointer at the last floor of this direction
    logic rev_empty; // nothing lies beyond the car in the opposite direction
    logic out_free;  // result register can take a new result
  } lesc_status_t;

endpackage

FILE: hdl/lesc_datapath.sv
// Datapath: floor flags, car position, scan pointer and result register.
module lesc_datapath #(
  parameter int FLOORS = lesc_pkg::FLOORS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lesc_pkg::lesc_cmd_t cmd,
  output lesc_pkg::lesc_status_t status,
  input  logic [7:0]          in_tdata,  // [4:0] floor, [7:5] zero
  input  logic [1:0]          in_tuser,  // [1:0] action
  output logic [15:0]         out_tdata, // [4:0] floor_now, [5] going_up,
                                         // [10:6] target_floor, [11] moved,
                                         // [12] door_opened, [13] drop_off
  output logic                out_tvalid,
  input  logic                out_tready
);
  import lesc_pkg::*;

  localparam int FW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam logic [6:0]    FLOORS_7 = 7'(FLOORS);
  localparam logic [FW-1:0] TOP      = FW'(FLOORS - 1);

  logic [ACTION_W-1:0] action;
  logic [FLOOR_W-1:0]  fl;
  logic [FLOORS-1:0]   hall_calls;
  logic [FLOORS-1:0]   car_targets;
  logic [FW-1:0]       car_floor;
  logic                heading_up;
  logic [FW-1:0]       ptr;
  logic [FW-1:0]       target;
  logic                moved;
  logic                door;
  logic                drop;

  logic                fl_ok;
  logic [FW-1:0]       fl_idx;
  logic [FLOORS-1:0]   pending;
  logic                up_forced;

  assign fl_ok   = {2'b00, fl} < FLOORS_7;
  assign fl_idx  = FW'(fl);
  assign pending = hall_calls | car_targets;

  // direction forced at the end floors
  always_comb begin
    if (car_floor >= TOP) begin
      up_forced = 1'b0;
    end else if (car_floor == '0) begin
      up_forced = 1'b1;
    end else begin
      up_forced = heading_up;
    end
  end

  // status to the controller
  always_comb begin
    status.is_step   = (action == ACT_STEP);
    status.hit       = pending[ptr];
    status.at_end    = heading_up ? (ptr == TOP) : (ptr == '0);
    status.rev_empty = heading_up ? (car_floor == '0) : (car_floor == TOP);
    status.out_free  = !out_tvalid || out_tready;
  end

  // captured transaction
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action <= in_tuser;
      fl     <= in_tdata[FLOOR_W-1:0];
    end
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      hall_calls  <= '0;
      car_targets <= '0;
      car_floor   <= '0;
      heading_up  <= 1'b1;
    end else begin
      if (cmd.serve) begin
        if (action == ACT_HALL && fl_ok) begin
          hall_calls[fl_idx] <= 1'b1;
        end else if (action == ACT_CAR && fl_ok) begin
          car_targets[fl_idx] <= 1'b1;
        end else if (action == ACT_STEP) begin
          hall_calls[car_floor]  <= 1'b0;
          car_targets[car_floor] <= 1'b0;
          heading_up             <= up_forced;
        end
      end
      if (cmd.found) begin
        car_floor <= ptr;
      end
      if (cmd.reverse) begin
        heading_up <= !heading_up;
      end
    end
  end

  // scan pointer and per-item result fields
  always_ff @(posedge clk) begin
    if (cmd.serve) begin
      target <= car_floor;
      moved  <= 1'b0;
      door   <= (action == ACT_STEP) && pending[car_floor];
      drop   <= (action == ACT_STEP) && car_targets[car_floor];
      ptr    <= up_forced ? car_floor + FW'(1) : car_floor - FW'(1);
    end
    if (cmd.advance) begin
      ptr <= heading_up ? ptr + FW'(1) : ptr - FW'(1);
    end
    if (cmd.reverse) begin
      ptr <= heading_up ? car_floor - FW'(1) : car_floor + FW'(1);
    end
    if (cmd.found) begin
      target <= ptr;
      moved  <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata <= {2'b00, drop, door, moved, 5'(target), heading_up, 5'(car_floor)};
    end
  end

endmodule

FILE: hdl/lesc_ctrl.sv
// Controller: sequences capture, serve, floor scan and result hand-off.
module lesc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  lesc_pkg::lesc_status_t status,
  output lesc_pkg::lesc_cmd_t    cmd
);
  import lesc_pkg::*;

  lesc_state_t state;
  lesc_state_t state_next;
  logic        second_pass;
  logic        second_pass_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      second_pass <= 1'b0;
    end else begin
      state       <= state_next;
      second_pass <= second_pass_next;
    end
  end

  // next state
  always_comb begin
    state_next       = state;
    second_pass_next = second_pass;
    case (state)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_next = ST_SERVE;
        end
      end
      ST_SERVE: begin
        second_pass_next = 1'b0;
        state_next       = status.is_step ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        if (status.hit) begin
          state_next = ST_FINISH;
        end else if (status.at_end) begin
          if (second_pass || status.rev_empty) begin
            state_next = ST_FINISH;
          end else begin
            second_pass_next = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      ST_SERVE: begin
        cmd.serve = 1'b1;
      end
      ST_SCAN: begin
        if (status.hit) begin
          cmd.found = 1'b1;
        end else if (status.at_end) begin
          cmd.reverse = !second_pass;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hdl/look_elevator_scheduler_unit.sv
// Top level of the LOOK elevator scheduler.
// One transaction is in work at a time. A hall call or car destination (tuser action 0 or 1)
// is accepted in the idle state, applied in the serve state and has its result loaded in the
// finish state, after which the unit returns to idle for the next transaction. A service step
// (action 2) also passes through the scan state between serve and finish, and that scan of the
// flag vectors checks one floor per cycle. The two scan passes together visit each floor other
// than the car's at most once. A result still waiting in the output register holds the next
// one in its finish state until the register frees. A new transaction is accepted while the
// previous result waits. Floors at or above FLOORS are ignored.
module look_elevator_scheduler_unit #(
  parameter int FLOORS = lesc_pkg::FLOORS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [4:0] floor, [7:5] zero
  input  logic [1:0]  s_tuser,  // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // [4:0] floor_now, [5] going_up, [10:6] target_floor,
                                // [11] moved, [12] door_opened, [13] drop_off, [15:14] zero
);
  import lesc_pkg::*;

  lesc_cmd_t    cmd;
  lesc_status_t status;

  lesc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_tvalid),
    .in_tready (s_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lesc_datapath #(
    .FLOORS (FLOORS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (s_tdata),
    .in_tuser   (s_tuser),
    .out_tdata  (m_tdata),
    .out_tvalid (m_tvalid),
    .out_tready (m_tready)
  );

endmodule
